// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; included by rpu_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rpu_pkg.sv =====
// Shared types and constants for the reaction propensity update core.
package rpu_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RATE  = 2'd1;
    localparam logic [1:0] OP_APPLY = 2'd2;

    localparam logic REG_RATE_CONSTANT   = 1'b0;
    localparam logic REG_REACTION_ACTIVE = 1'b1;

    localparam int CNT_W   = 32;
    localparam int RC_W    = 48;
    localparam int RATE_W  = 64;
    localparam int ORDER_W = 3;
    localparam int DELTA_W = 6;

    // One request as it sits in the queue between front and back.
    typedef struct packed {
        logic [1:0]         op;
        logic [4:0]         slot;
        logic [CNT_W-1:0]   count;
        logic [ORDER_W-1:0] order;
        logic [DELTA_W-1:0] delta;
        logic               clamped;
    } t_req;

endpackage

// ===== rtl/rpu_front.sv =====
// Front end: accepts requests and queues them toward the back end.
module rpu_front #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rpu_pkg::t_req i_req,
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output rpu_pkg::t_req o_q_req
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rpu_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          push, pop;

    assign o_stall   = (r_cnt == (PW+1)'(DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_mem[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end
endmodule

// ===== rtl/rpu_back.sv =====
// Back end: slot table, rate product walk and firing walk.
`include "assert_macros.svh"
module rpu_back #(
    parameter int SLOTS     = 32,
    parameter int MAX_ORDER = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  rpu_pkg::t_req               i_q_req,
    input  logic [rpu_pkg::RC_W-1:0]    i_rate_constant,
    input  logic                        i_reaction_active,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rpu_pkg::RATE_W-1:0]  o_rate_value,
    output logic [31:0]                 o_fire_count,
    output logic                        o_saturated,
    output logic                        o_underflow
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RATE, S_MUL, S_FIN, S_APPLY
    } t_state;

    t_state r_state;
    logic [31:0]         r_cnt [SLOTS];
    logic [2:0]          r_ord [SLOTS];
    logic signed [5:0]   r_dlt [SLOTS];
    logic [SLOTS-1:0]    r_clp;
    logic [SW-1:0]       r_idx;
    logic [2:0]          r_k;
    logic [63:0]         r_prod;
    logic                r_ovf, r_zero, r_sat, r_und;
    logic                r_apply;
    logic [31:0]         r_fires;
    logic [111:0]        r_acc;
    logic                r_out_v;
    logic [63:0]         r_out_rate;
    logic                r_out_sat, r_out_und;

    // per-step factor and 64x32 saturating multiply split over 32-bit halves
    logic [31:0] fac;
    logic [63:0] pl, ph;
    logic [64:0] mix;
    logic        step_ovf;
    logic [2:0]  cur_ord;
    logic [31:0] cur_cnt;
    logic        last;
    logic signed [33:0] nc;
    logic        out_free;
    logic [4:0]  wr_slot;

    // product times the 48-bit constant: four 32x24 partial products, one per cycle
    logic [31:0]  mul_a;
    logic [23:0]  mul_b;
    logic [55:0]  mul_p;
    logic [111:0] mul_term;

    assign cur_ord  = r_ord[r_idx];
    assign cur_cnt  = r_cnt[r_idx];
    assign fac      = cur_cnt - {29'd0, r_k};
    assign pl       = {32'd0, r_prod[31:0]} * {32'd0, fac};
    assign ph       = {32'd0, r_prod[63:32]} * {32'd0, fac};
    assign mix      = {1'b0, ph} + {33'd0, pl[63:32]};
    assign step_ovf = (mix[64:32] != '0);
    assign last     = (r_idx == SW'(SLOTS-1));
    assign nc       = $signed({2'b00, cur_cnt}) + 34'(r_dlt[r_idx]);
    assign out_free = !r_out_v || !i_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && out_free;
    assign wr_slot  = i_q_req.slot;

    assign mul_a = r_k[1] ? r_prod[63:32] : r_prod[31:0];
    assign mul_b = r_k[0] ? i_rate_constant[47:24] : i_rate_constant[23:0];
    assign mul_p = {24'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        case (r_k[1:0])
            2'd0:    mul_term = {56'd0, mul_p};
            2'd1:    mul_term = {32'd0, mul_p, 24'd0};
            2'd2:    mul_term = {24'd0, mul_p, 32'd0};
            default: mul_term = {mul_p, 56'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_fires <= '0;
            r_idx   <= '0;
            r_k     <= '0;
            r_clp   <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_cnt[s] <= '0;
                r_ord[s] <= '0;
                r_dlt[s] <= '0;
            end
        end else begin
            if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_idx   <= '0;
                        r_k     <= '0;
                        r_prod  <= 64'd1;
                        r_acc   <= '0;
                        r_ovf   <= 1'b0;
                        r_zero  <= 1'b0;
                        r_sat   <= 1'b0;
                        r_und   <= 1'b0;
                        r_apply <= (i_q_req.op == rpu_pkg::OP_APPLY);
                        case (i_q_req.op)
                            rpu_pkg::OP_RATE: begin
                                if (!i_reaction_active) begin
                                    r_out_v    <= 1'b1;
                                    r_out_rate <= '0;
                                    r_out_sat  <= 1'b0;
                                    r_out_und  <= 1'b0;
                                end else begin
                                    r_state <= S_RATE;
                                end
                            end
                            rpu_pkg::OP_APPLY: r_state <= S_APPLY;
                            default: begin
                                if (i_q_req.op == rpu_pkg::OP_WRITE &&
                                    32'(wr_slot) < SLOTS) begin
                                    r_cnt[SW'(wr_slot)] <= i_q_req.count;
                                    r_ord[SW'(wr_slot)] <=
                                        (i_q_req.order > 3'(MAX_ORDER)) ?
                                        3'(MAX_ORDER) : i_q_req.order;
                                    r_dlt[SW'(wr_slot)] <= i_q_req.delta;
                                    r_clp[SW'(wr_slot)] <= i_q_req.clamped;
                                end
                                r_out_v    <= 1'b1;
                                r_out_rate <= '0;
                                r_out_sat  <= 1'b0;
                                r_out_und  <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RATE: begin
                    // one factor per cycle; k walks the order of the slot
                    if (cur_ord != '0 && cur_cnt < {29'd0, cur_ord}) begin
                        r_zero <= 1'b1;
                    end
                    if (cur_ord != '0 && r_k < cur_ord) begin
                        if (step_ovf || r_ovf) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_prod <= {mix[31:0], pl[31:0]};
                        end
                        r_k <= r_k + 3'd1;
                    end else begin
                        r_k <= '0;
                        if (last) begin
                            r_state <= S_MUL;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_acc <= r_acc + mul_term;
                    if (r_k == 3'd3) begin
                        r_k     <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_v <= 1'b1;
                        if (r_apply) begin
                            r_out_rate <= '0;
                            r_out_sat  <= r_sat;
                            r_out_und  <= r_und;
                        end else if (r_zero || i_rate_constant == '0) begin
                            r_out_rate <= '0;
                            r_out_sat  <= 1'b0;
                            r_out_und  <= 1'b0;
                        end else if (r_ovf || r_acc[111:64] != '0) begin
                            r_out_rate <= '1;
                            r_out_sat  <= 1'b1;
                            r_out_und  <= 1'b0;
                        end else begin
                            r_out_rate <= r_acc[63:0];
                            r_out_sat  <= 1'b0;
                            r_out_und  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_APPLY: begin
                    if (!r_clp[r_idx] && r_dlt[r_idx] != '0) begin
                        if (nc < 0) begin
                            r_cnt[r_idx] <= '0;
                            r_und <= 1'b1;
                        end else if (nc[32]) begin
                            r_cnt[r_idx] <= '1;
                            r_sat <= 1'b1;
                        end else begin
                            r_cnt[r_idx] <= nc[31:0];
                        end
                    end
                    if (last) begin
                        r_state <= S_FIN;
                        r_fires <= r_fires + 32'd1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_v;
    assign o_rate_value = r_out_rate;
    assign o_fire_count = r_fires;
    assign o_saturated  = r_out_sat;
    assign o_underflow  = r_out_und;

    `ASSERT_IMP(a_sat_rate, i_clk, i_rst_n, o_valid && o_underflow, o_rate_value == '0, "underflow with rate")
    `ASSERT_NEXT(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_state != S_FIN, "pop then fin")
    `ASSERT_IMP(a_idx, i_clk, i_rst_n, r_state == S_IDLE, r_idx == '0 || r_idx == SW'(SLOTS-1), "idx")
endmodule

// ===== rtl/reaction_propensity_update_core.sv =====
// Writes are taken one per cycle while the output is not stalled; a rate
// request on an active reaction or an apply request holds the back end
// until its result is registered.
// Front queue of two requests decouples input stall from the walk.
// Synchronous active-low reset clears the slot table and firing count and resets the config.
// Reset leaves reaction_active at 1 and rate_constant at 0.
module reaction_propensity_update_core #(
    parameter int SLOTS     = 32,
    parameter int MAX_ORDER = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [4:0]  i_slot,
    input  logic [31:0] i_count,
    input  logic [2:0]  i_order,
    input  logic [5:0]  i_delta,
    input  logic        i_clamped,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_rate_value,
    output logic [31:0] o_fire_count,
    output logic        o_saturated,
    output logic        o_underflow
);
    logic [47:0]   r_rate_constant;
    logic          r_reaction_active;
    rpu_pkg::t_req req, q_req;
    logic          q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_constant   <= '0;
            r_reaction_active <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rpu_pkg::REG_RATE_CONSTANT) begin
                r_rate_constant <= i_cfg_data;
            end else begin
                r_reaction_active <= i_cfg_data[0];
            end
        end
    end

    assign req = '{op: i_op, slot: i_slot, count: i_count, order: i_order,
                   delta: i_delta, clamped: i_clamped};

    rpu_front #(.DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req(req),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_req(q_req)
    );

    rpu_back #(.SLOTS(SLOTS), .MAX_ORDER(MAX_ORDER)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_req(q_req),
        .i_rate_constant(r_rate_constant), .i_reaction_active(r_reaction_active),
        .o_valid, .i_stall, .o_rate_value, .o_fire_count, .o_saturated, .o_underflow
    );
endmodule

// ===== sim/reaction_propensity_update_core_tb.sv =====
// Testbench for reaction_propensity_update_core: scoreboard-checked random and directed requests.
module reaction_propensity_update_core_tb;

    typedef struct {
        logic [63:0] rate_value;
        logic [31:0] fire_count;
        logic        saturated;
        logic        underflow;
    } t_res;

    // Scoreboard: own copy of slot table and config, predicts one result per request.
    class propensity_board;
        logic [47:0] rc;
        logic        active;
        logic [31:0] cnt [32];
        logic [2:0]  ord [32];
        logic signed [5:0] dlt [32];
        logic        clp [32];
        logic [31:0] firings;
        t_res        pending [$];
        int          errors;

        function void clear();
            rc = '0;
            active = 1'b1;
            firings = '0;
            errors = 0;
            for (int s = 0; s < 32; s++) begin
                cnt[s] = '0; ord[s] = '0; dlt[s] = '0; clp[s] = 1'b0;
            end
        endfunction

        function void note_config(logic idx, logic [47:0] data);
            if (idx == rpu_pkg::REG_RATE_CONSTANT) rc = data;
            else active = data[0];
        endfunction

        function void note_request(rpu_pkg::t_req r);
            t_res e;
            logic [127:0] wide;
            logic [63:0] prod;
            logic ovf, zero;
            longint signed nc;
            e = '{64'd0, 32'd0, 1'b0, 1'b0};
            if (r.op == rpu_pkg::OP_WRITE) begin
                cnt[r.slot] = r.count;
                ord[r.slot] = (r.order > 3'd4) ? 3'd4 : r.order;
                dlt[r.slot] = r.delta;
                clp[r.slot] = r.clamped;
            end else if (r.op == rpu_pkg::OP_RATE) begin
                prod = 64'd1; ovf = 1'b0; zero = !active;
                for (int s = 0; s < 32 && !zero; s++) begin
                    if (ord[s] != 0) begin
                        if (cnt[s] < ord[s]) zero = 1'b1;
                        else for (int k = 0; k < ord[s]; k++) begin
                            wide = prod * (cnt[s] - k);
                            if (wide[127:64] != 0) begin ovf = 1'b1; prod = '1; end
                            else prod = wide[63:0];
                        end
                    end
                end
                if (!zero && rc != 0) begin
                    if (ovf) begin e.rate_value = '1; e.saturated = 1'b1; end
                    else begin
                        wide = prod * rc;
                        if (wide[127:64] != 0) begin
                            e.rate_value = '1; e.saturated = 1'b1;
                        end else e.rate_value = wide[63:0];
                    end
                end
            end else if (r.op == rpu_pkg::OP_APPLY) begin
                for (int s = 0; s < 32; s++) begin
                    if (!clp[s] && dlt[s] != 0) begin
                        nc = longint'(cnt[s]) + longint'(dlt[s]);
                        if (nc < 0) begin nc = 0; e.underflow = 1'b1; end
                        else if (nc > 64'hFFFF_FFFF) begin
                            nc = 64'hFFFF_FFFF; e.saturated = 1'b1;
                        end
                        cnt[s] = nc[31:0];
                    end
                end
                firings = firings + 1;
            end
            e.fire_count = firings;
            pending.push_back(e);
        endfunction

        function void check_result(t_res a);
            t_res e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.rate_value !== e.rate_value) begin
                $error("rate_value exp %h got %h", e.rate_value, a.rate_value); errors++;
            end
            if (a.fire_count !== e.fire_count) begin
                $error("fire_count exp %h got %h", e.fire_count, a.fire_count); errors++;
            end
            if (a.saturated !== e.saturated) begin
                $error("saturated exp %b got %b", e.saturated, a.saturated); errors++;
            end
            if (a.underflow !== e.underflow) begin
                $error("underflow exp %b got %b", e.underflow, a.underflow); errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_cfg_we, i_cfg_index, i_valid, i_stall, i_clamped;
    logic [47:0] i_cfg_data;
    logic [1:0]  i_op;
    logic [4:0]  i_slot;
    logic [31:0] i_count;
    logic [2:0]  i_order;
    logic [5:0]  i_delta;
    logic        o_stall, o_valid, o_saturated, o_underflow;
    logic [63:0] o_rate_value;
    logic [31:0] o_fire_count;

    propensity_board board;
    bit          calm;  // no idling on either side while set

    reaction_propensity_update_core u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stall, check on accept.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(t_res'{o_rate_value, o_fire_count, o_saturated, o_underflow});
        i_stall <= !calm && ($urandom_range(99) < 17);
    end

    // valid stays high into the next request; send drops it only while idling
    task automatic send(rpu_pkg::t_req r);
        while (!calm && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= r.op; i_slot <= r.slot; i_count <= r.count;
        i_order <= r.order; i_delta <= r.delta; i_clamped <= r.clamped;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic write_cfg(logic idx, logic [47:0] data);
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        board.note_config(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    function automatic rpu_pkg::t_req mk(int op, int slot, logic [31:0] c,
                                         int o, int d, int cl);
        rpu_pkg::t_req r;
        r.op = 2'(op); r.slot = 5'(slot); r.count = c; r.order = 3'(o);
        r.delta = 6'(d); r.clamped = 1'(cl);
        return r;
    endfunction

    function automatic rpu_pkg::t_req rnd_req();
        rpu_pkg::t_req r;
        int p;
        p = $urandom_range(99);
        r.op = (p < 50) ? rpu_pkg::OP_WRITE : (p < 75) ? rpu_pkg::OP_RATE
             : (p < 97) ? rpu_pkg::OP_APPLY : 2'd3;
        r.slot = 5'($urandom_range(7));
        if ($urandom_range(9) == 0) r.slot = 5'($urandom);
        p = $urandom_range(9);
        r.count = (p < 6) ? $urandom_range(40) : (p < 8) ? $urandom
                : 32'hFFFF_FFFF - $urandom_range(20);
        r.order = (p == 9 && $urandom_range(1)) ? 3'd0 : 3'($urandom_range(7));
        if ($urandom_range(2) != 0 && r.order > 2) r.order = 3'($urandom_range(2));
        r.delta = 6'($urandom);
        r.clamped = ($urandom_range(3) == 0);
        return r;
    endfunction

    initial begin
        logic [47:0] rcs [6];
        board = new();
        board.clear();
        calm = 1'b1;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        i_valid = 1'b0; i_stall = 1'b0; i_op = '0; i_slot = '0; i_count = '0;
        i_order = '0; i_delta = '0; i_clamped = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, zero constant, extremes, inactive, op 3
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));
        write_cfg(rpu_pkg::REG_RATE_CONSTANT, 48'h1_0000_0000);
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));
        send(mk(rpu_pkg::OP_WRITE, 0, 5, 2, 6'sd16, 0));
        send(mk(rpu_pkg::OP_WRITE, 31, 32'hFFFF_FFFF, 7, 6'h3F, 0));
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));
        send(mk(rpu_pkg::OP_WRITE, 31, 3, 4, 6'h30, 0));
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));           // count below order
        send(mk(rpu_pkg::OP_APPLY, 0, 0, 0, 0, 0));          // underflow
        send(mk(rpu_pkg::OP_WRITE, 1, 32'hFFFF_FFF8, 4, 6'sd16, 0));
        send(mk(rpu_pkg::OP_APPLY, 0, 0, 0, 0, 0));          // count saturates
        send(mk(rpu_pkg::OP_WRITE, 31, 0, 0, 0, 1));
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));           // product overflow
        send(mk(3, 3, 9, 1, 1, 1));
        write_cfg(rpu_pkg::REG_RATE_CONSTANT, 48'd0);
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));           // overflow but zero constant
        write_cfg(rpu_pkg::REG_RATE_CONSTANT, 48'hFFFF_FFFF_FFFF);
        write_cfg(rpu_pkg::REG_REACTION_ACTIVE, 48'd0);
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));
        send(mk(rpu_pkg::OP_APPLY, 0, 0, 0, 0, 0));          // applies while inactive
        write_cfg(rpu_pkg::REG_REACTION_ACTIVE, 48'd1);
        send(mk(rpu_pkg::OP_WRITE, 1, 7, 1, 0, 1));
        send(mk(rpu_pkg::OP_WRITE, 0, 2, 1, 6'h20, 0));
        send(mk(rpu_pkg::OP_RATE, 0, 0, 0, 0, 0));
        send(mk(rpu_pkg::OP_APPLY, 0, 0, 0, 0, 0));

        rcs = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'h1_0000_0000, 48'd1, 48'h0_8000_0000, 48'd0};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                write_cfg(rpu_pkg::REG_RATE_CONSTANT,
                          (ph < 6) ? rcs[ph] : 48'({$urandom, $urandom}));
                write_cfg(rpu_pkg::REG_REACTION_ACTIVE, 48'({$urandom, $urandom}));
                if (ph == 3) write_cfg(rpu_pkg::REG_REACTION_ACTIVE, 48'd1);
            end
            calm = (ph == 2);
            for (int n = 0; n < 50; n++) send(rnd_req());
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
